/* rtl/fpcc_pkg.sv */
// Shared types, constants and the CRC byte update of the packet CRC checker.
package fpcc_pkg;

  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [15:0] CrcSeedReset = 16'hFFFF;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  // Kind code of a result.
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One result, before packing onto the master-side stream.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        crc_ok;
    logic [15:0] crc_computed;
    logic [15:0] crc_received;
    logic [7:0]  trigger_number;
    logic [3:0]  trigger_flag;
    logic        too_short;
    logic        run_last;
  } result_t;

  // Results made by one input transaction: count, then up to two in order.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  // CRC-16 update with one byte, MSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/fpcc_core.sv */
// Packet state, CRC update and result building of the packet CRC checker.
module fpcc_core
  import fpcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_fire_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        in_ok_i,
  output push_t       push_o
);

  logic [15:0] seed_q;
  logic [15:0] crc_q, crc_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  dly_q [4];
  logic [15:0] crc_base;
  logic [15:0] crc_cur;
  logic        pay_valid;
  logic        short_pkt;
  logic [15:0] rx_crc;
  result_t     pay_res;
  result_t     sum_res;

  // CRC: the byte two places back enters from the third byte on.
  always_comb begin
    crc_base = (pos_q <= 3'd2) ? seed_q : crc_q;
    crc_cur  = (pos_q >= 3'd2) ? crc_byte(crc_base, dly_q[1]) : crc_base;
  end

  // Payload and summary results of this transaction.
  always_comb begin
    pay_valid = (pos_q >= 3'd6);
    short_pkt = (pos_q < 3'd5);
    rx_crc    = {dly_q[0], in_byte_i};

    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = dly_q[3];
    pay_res.run_last     = ~in_last_i;

    sum_res                = '0;
    sum_res.kind           = KIND_SUMMARY;
    sum_res.crc_ok         = ~short_pkt & in_ok_i & (crc_cur == rx_crc);
    sum_res.crc_computed   = crc_cur;
    sum_res.crc_received   = rx_crc;
    sum_res.trigger_number = dly_q[1];
    sum_res.trigger_flag   = dly_q[2][7:4];
    sum_res.too_short      = short_pkt;
    sum_res.run_last       = 1'b1;

    push_o = '0;
    if (in_fire_i) begin
      if (pay_valid) begin
        push_o.first  = pay_res;
        push_o.second = sum_res;
        push_o.num    = in_last_i ? 2'd2 : 2'd1;
      end else if (in_last_i) begin
        push_o.first = sum_res;
        push_o.num   = 2'd1;
      end
    end
  end

  // Next packet position and CRC register.
  always_comb begin
    crc_d = crc_cur;
    pos_d = (pos_q < 3'd6) ? pos_q + 3'd1 : pos_q;
    if (in_last_i) begin
      crc_d = seed_q;
      pos_d = '0;
    end
  end

  // Seed register, packet position, CRC and byte delay line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= CrcSeedReset;
      crc_q  <= CrcSeedReset;
      pos_q  <= '0;
      for (int i = 0; i < 4; i++) begin
        dly_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (in_fire_i) begin
        crc_q <= crc_d;
        pos_q <= pos_d;
        if (in_last_i) begin
          for (int i = 0; i < 4; i++) begin
            dly_q[i] <= '0;
          end
        end else begin
          dly_q[3] <= dly_q[2];
          dly_q[2] <= dly_q[1];
          dly_q[1] <= dly_q[0];
          dly_q[0] <= in_byte_i;
        end
      end
    end
  end

endmodule

/* rtl/fpcc_res_fifo.sv */
// Result queue that takes up to two results a cycle and hands out one.
module fpcc_res_fifo
  import fpcc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room2_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  result_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wp_q, wp_d;
  logic [QueuePtrW-1:0]  rp_q, rp_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  pop;

  // Handshake and occupancy.
  always_comb begin
    out_valid_o = (cnt_q != '0);
    out_data_o  = mem_q[rp_q];
    room2_o     = (cnt_q <= QueueCntW'(QueueDepth - 2));
    pop         = out_valid_o & out_ready_i;
    wp_d        = wp_q + QueuePtrW'(push_i.num);
    rp_d        = rp_q + QueuePtrW'(pop);
    cnt_d       = cnt_q + QueueCntW'(push_i.num) - QueueCntW'(pop);
  end

  // Storage writes; no reset needed on the payload.
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wp_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wp_q + QueuePtrW'(1)] <= push_i.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/fee_packet_crc_checker_unit.sv */
// Top level of the front-end packet CRC checker.
//
// Takes one packet byte per transaction (2 length bytes, payload, 2 trigger bytes,
// 2 CRC bytes, tlast on the final byte) and forwards payload bytes through a
// four-byte delay line, followed at the final byte by a summary with the
// CRC-16/CCITT result (poly 0x1021, seeded from cfg_wdata_i) computed over all
// but the last two bytes. The block takes one transaction per cycle while the
// result queue has room. The final byte of a packet longer than six bytes
// makes two results; these go into a four-entry result queue, and a byte is
// accepted only while the queue has room for two results. The seed may be
// written between packets and takes effect on any packet that has not yet
// seen its third byte.
module fee_packet_crc_checker_unit
  import fpcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_packet
  input  logic        s_axis_tuser,   // upstream_ok
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] crc_ok, [24:9] crc_computed, [40:25] crc_received,
  // [48:41] trigger_number, [52:49] trigger_flag, [53] too_short, [55:54] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // kind
);

  push_t   push;
  result_t res;
  logic    room2;
  logic    in_fire;

  assign s_axis_tready = room2;
  assign in_fire       = s_axis_tvalid & room2;

  // Packet state and result building.
  fpcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_ok_i     (s_axis_tuser),
    .push_o      (push)
  );

  // Result queue toward the master side.
  fpcc_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // Pack the result onto the stream.
  assign m_axis_tdata = {2'b00, res.too_short, res.trigger_flag, res.trigger_number,
                         res.crc_received, res.crc_computed, res.crc_ok,
                         res.payload_byte};
  assign m_axis_tlast = res.run_last;
  assign m_axis_tuser = res.kind;

endmodule

/* tb/tb_fee_packet_crc_checker_unit.sv */
// Self-checking testbench for the front-end packet CRC checker: directed and random packets.
`timescale 1ns / 100ps

module tb_fee_packet_crc_checker_unit
  import fpcc_pkg::*;
();

  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned StallLimit   = 4000;
  localparam logic [15:0] CrcPolyTb    = 16'h1021;

  // How the bytes of a packet body are filled.
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // Predicted block state, kept in step with every accepted byte.
  logic [15:0] model_seed = CrcSeedReset;
  logic [15:0] model_crc  = CrcSeedReset;
  logic [7:0]  byte_hist [4] = '{default: '0};
  logic [2:0]  byte_pos   = '0;

  result_t     pending_packet_results [$];
  int unsigned error_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned quiet_cycles  = 0;

  fee_packet_crc_checker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // The receiver stalls at random with the current percentage.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // CRC-16 update, one input bit at a time, MSB first.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CrcPolyTb : 16'h0000);
    end
    return crc;
  endfunction

  // Advances the predicted state by one byte and queues the results it causes.
  function automatic void model_packet_byte(logic [7:0] b, logic last, logic up_ok);
    logic [15:0] cur;
    logic [15:0] rx;
    logic        short_pkt;
    result_t     r;
    cur = (byte_pos <= 3'd2) ? model_seed : model_crc;
    if (byte_pos >= 3'd2) begin
      cur = crc16_step(cur, byte_hist[1]);
    end
    model_crc = cur;

    // Once six bytes are in, the oldest delayed byte leaves as payload.
    if (byte_pos >= 3'd6) begin
      r              = '0;
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = byte_hist[3];
      r.run_last     = !last;
      pending_packet_results = {pending_packet_results, r};
    end

    if (last) begin
      short_pkt        = (byte_pos < 3'd5);
      rx               = {byte_hist[0], b};
      r                = '0;
      r.kind           = KIND_SUMMARY;
      r.crc_ok         = !short_pkt && up_ok && (cur == rx);
      r.crc_computed   = cur;
      r.crc_received   = rx;
      r.trigger_number = byte_hist[1];
      r.trigger_flag   = byte_hist[2][7:4];
      r.too_short      = short_pkt;
      r.run_last       = 1'b1;
      pending_packet_results = {pending_packet_results, r};
      model_crc = model_seed;
      byte_hist = '{default: '0};
      byte_pos  = '0;
    end else begin
      byte_hist[3] = byte_hist[2];
      byte_hist[2] = byte_hist[1];
      byte_hist[1] = byte_hist[0];
      byte_hist[0] = b;
      if (byte_pos < 3'd6) begin
        byte_pos = byte_pos + 3'd1;
      end
    end
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Every accepted result transaction is compared with the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_packet_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_packet_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
        check_field("payload_byte", 16'(want.payload_byte), 16'(m_axis_tdata[7:0]));
        check_field("crc_ok", 16'(want.crc_ok), 16'(m_axis_tdata[8]));
        check_field("crc_computed", want.crc_computed, m_axis_tdata[24:9]);
        check_field("crc_received", want.crc_received, m_axis_tdata[40:25]);
        check_field("trigger_number", 16'(want.trigger_number), 16'(m_axis_tdata[48:41]));
        check_field("trigger_flag", 16'(want.trigger_flag), 16'(m_axis_tdata[52:49]));
        check_field("too_short", 16'(want.too_short), 16'(m_axis_tdata[53]));
        check_field("pad_bits", 16'h0000, 16'(m_axis_tdata[55:54]));
        check_field("run_last", 16'(want.run_last), 16'(m_axis_tlast));
      end
    end
  end

  // Ends the run when no transaction has moved on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t ns: no transaction for %0d cycles", $time, StallLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one byte, with random idle cycles ahead of it, and predicts its results.
  task automatic send_byte(logic [7:0] b, logic last, logic up_ok);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tuser  <= up_ok;
    do @(posedge clk_i); while (!s_axis_tready);
    model_packet_byte(b, last, up_ok);
    bytes_sent++;
  endtask

  // Builds one packet; with good_crc the final two bytes carry the matching CRC.
  task automatic send_packet(int len, fill_e fill, bit good_crc, bit up_ok);
    logic [7:0]  pkt [$];
    logic [15:0] crc;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: pkt = {pkt, 8'h00};
        FILL_ONES: pkt = {pkt, 8'hFF};
        default:   pkt = {pkt, 8'($urandom_range(255))};
      endcase
    end
    if (good_crc && len >= 2) begin
      crc = model_seed;
      for (int i = 0; i < len - 2; i++) begin
        crc = crc16_step(crc, pkt[i]);
      end
      pkt[len - 2] = crc[15:8];
      pkt[len - 1] = crc[7:0];
    end
    // The upstream flag only counts on the final byte; the others get noise.
    for (int i = 0; i < len; i++) begin
      send_byte(pkt[i], i == len - 1, (i == len - 1) ? up_ok : 1'($urandom_range(1)));
    end
  endtask

  // Writes the seed once all results are out and the block has settled.
  task automatic write_seed(logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_packet_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_seed  = value;
  endtask

  // Mostly well-formed packets, with some short ones and some bad CRCs.
  task automatic run_random_traffic(int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    int          len;
    target = bytes_sent + n_items;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = $urandom_range(24, 6);
      end else if (pick < 90) begin
        len = $urandom_range(5, 1);
      end else begin
        len = $urandom_range(48, 25);
      end
      send_packet(len, FILL_RANDOM, $urandom_range(99) < 75, $urandom_range(99) < 90);
    end
  endtask

  // Packets under six bytes, with the reset seed, at both byte extremes.
  task automatic test_short_packets();
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    send_packet(1, FILL_ONES, 1'b0, 1'b1);
    send_packet(2, FILL_ZERO, 1'b0, 1'b1);
    send_packet(3, FILL_ONES, 1'b1, 1'b1);
    send_packet(5, FILL_ONES, 1'b1, 1'b1);
  endtask

  // Seed extremes: a good seven-byte packet on a zero seed, then a six-byte
  // packet with no payload and the upstream flag clear.
  task automatic test_seed_extremes();
    write_seed(16'h0000);
    send_packet(7, FILL_ZERO, 1'b1, 1'b1);
    write_seed(16'hFFFF);
    send_packet(6, FILL_ONES, 1'b1, 1'b0);
  endtask

  task automatic test_sender_gaps();
    write_seed(16'($urandom));
    src_idle_pct = 32;
    rcv_idle_pct = 65;
    run_random_traffic(370);
  endtask

  task automatic test_receiver_gaps();
    write_seed(16'($urandom));
    src_idle_pct = 65;
    rcv_idle_pct = 32;
    run_random_traffic(370);
  endtask

  task automatic test_full_rate();
    write_seed(16'($urandom));
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random_traffic(370);
  endtask

  // Test sequence and final verdict.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_short_packets();
    test_seed_extremes();
    test_sender_gaps();
    test_receiver_gaps();
    test_full_rate();
    s_axis_tvalid <= 1'b0;
    while (pending_packet_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
